// ----- rtl/core/tlwpc_pkg.sv -----
`default_nettype none

package tlwpc_pkg;

    // Fixed field widths of the item and result
    localparam int AddrFieldW = 24;
    localparam int PageW      = 15;
    localparam int OffMaxW    = 12;
    localparam int FillOffW   = 9;

    // Parameter defaults
    localparam int PageBytesDef = 512;
    localparam int LowBytesDef  = 512;
    localparam int AddrBitsDef  = 24;

    // Access modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_FILL  = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_READ  = 3'd0;
    localparam logic [2:0] KIND_WRITE = 3'd1;
    localparam logic [2:0] KIND_MISS  = 3'd2;
    localparam logic [2:0] KIND_FILL  = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    // Item class decided by the front end
    typedef enum logic [1:0] {
        CLS_LOW,
        CLS_PAGE,
        CLS_FILL,
        CLS_BAD
    } cls_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic [AddrFieldW-1:0] address;
        logic [7:0]            write_data;
        logic [7:0]            fill_data;
    } access_t;

    typedef struct packed {
        logic [2:0]          kind;
        logic [7:0]          read_data;
        logic [PageW-1:0]    fill_page;
        logic                writeback_needed;
        logic [PageW-1:0]    writeback_page;
        logic [7:0]          old_byte;
        logic [FillOffW-1:0] fill_offset;
        logic                last;
    } result_t;

    // Decoded item passed from front to back
    typedef struct packed {
        cls_t               cls;
        logic               is_write;
        logic [PageW-1:0]   page;
        logic [OffMaxW-1:0] offset;
        logic [7:0]         data;
    } job_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC,
        BK_RDOUT,
        BK_FILL_OLD,
        BK_FILL_WR,
        BK_FILL_RDI,
        BK_FILL_RDO
    } back_state_t;

    typedef struct packed {
        logic ready;
        logic fill_pending;
        logic victim_valid;
    } back_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/tlwpc_front.sv -----
`default_nettype none

module tlwpc_front #(
    parameter int PAGE_BYTES = tlwpc_pkg::PageBytesDef,
    parameter int LOW_BYTES  = tlwpc_pkg::LowBytesDef,
    parameter int ADDR_BITS  = tlwpc_pkg::AddrBitsDef
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire tlwpc_pkg::access_t access,
    input  wire logic              ready,
    input  wire logic              q_full,
    output logic                   q_push,
    output tlwpc_pkg::job_t        q_item
);

    localparam int  OFF_W   = $clog2(PAGE_BYTES);
    localparam int  AF_W    = tlwpc_pkg::AddrFieldW;
    localparam bit  IS_POW2 = ((PAGE_BYTES & (PAGE_BYTES - 1)) == 0);

    logic [AF_W-1:0]  addr_m;
    logic             is_low;
    tlwpc_pkg::job_t  dec;

    // Address wrap and static classification
    always_comb
    begin
        for (int i = 0; i < AF_W; i++)
        begin
            addr_m[i] = (i < ADDR_BITS) && access.address[i];
        end
        is_low       = 32'(addr_m) < 32'(LOW_BYTES);
        dec          = '0;
        dec.is_write = (access.mode == tlwpc_pkg::MODE_WRITE);
        dec.data     = (access.mode == tlwpc_pkg::MODE_FILL) ? access.fill_data
                                                              : access.write_data;
        case (access.mode)
            tlwpc_pkg::MODE_READ, tlwpc_pkg::MODE_WRITE:
            begin
                dec.cls = is_low ? tlwpc_pkg::CLS_LOW : tlwpc_pkg::CLS_PAGE;
            end
            tlwpc_pkg::MODE_FILL:
            begin
                dec.cls = tlwpc_pkg::CLS_FILL;
            end
            default:
            begin
                dec.cls = tlwpc_pkg::CLS_BAD;
            end
        endcase
        if (is_low)
        begin
            dec.offset = addr_m[tlwpc_pkg::OffMaxW-1:0];
        end
        else
        begin
            dec.offset = tlwpc_pkg::OffMaxW'(addr_m[OFF_W-1:0]);
        end
    end

    generate
        if (IS_POW2)
        begin : g_shift
            tlwpc_pkg::job_t stg_reg;
            tlwpc_pkg::job_t stg_next;
            logic            stg_valid_reg;
            logic            acc;

            // Page split is a shift; one decode stage in front of the queue
            always_comb
            begin
                full          = !ready || (stg_valid_reg && q_full);
                acc           = push && !full;
                q_push        = stg_valid_reg && !q_full;
                q_item        = stg_reg;
                stg_next      = dec;
                stg_next.page = tlwpc_pkg::PageW'(addr_m >> OFF_W);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stg_valid_reg <= 1'b0;
                end
                else if (acc)
                begin
                    stg_valid_reg <= 1'b1;
                end
                else if (q_push)
                begin
                    stg_valid_reg <= 1'b0;
                end
            end

            always_ff @(posedge clk)
            begin
                if (acc)
                begin
                    stg_reg <= stg_next;
                end
            end
        end
        else
        begin : g_div
            // Rounded-up reciprocal of the page size, exact for every AF_W-bit address
            localparam int SHIFT   = AF_W + OFF_W;
            localparam int RECIP_W = AF_W + 1;
            localparam int PROD_W  = AF_W + RECIP_W;
            localparam longint unsigned RECIP =
                ((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);

            tlwpc_pkg::job_t   hold_reg;
            logic [AF_W-1:0]   addr_reg;
            logic [AF_W-1:0]   quo_reg, quo_next;
            logic [OFF_W-1:0]  rem_reg, rem_next;
            logic [1:0]        step_reg, step_next;
            logic              busy_reg, busy_next;
            logic [PROD_W-1:0] prod;
            logic [AF_W-1:0]   back_mul;
            logic              acc;
            logic              done;

            // Quotient by reciprocal multiply, then remainder by multiply-subtract
            always_comb
            begin
                full      = !ready || busy_reg;
                acc       = push && !full;
                done      = (step_reg == 2'd2);
                prod      = PROD_W'(addr_reg) * PROD_W'(RECIP_W'(RECIP));
                back_mul  = AF_W'(quo_reg * AF_W'(PAGE_BYTES));
                quo_next  = quo_reg;
                rem_next  = rem_reg;
                step_next = step_reg;
                busy_next = busy_reg;
                q_item    = hold_reg;
                q_item.page = tlwpc_pkg::PageW'(quo_reg);
                if (hold_reg.cls == tlwpc_pkg::CLS_PAGE)
                begin
                    q_item.offset = tlwpc_pkg::OffMaxW'(rem_reg);
                end
                q_push    = busy_reg && done && !q_full;
                if (acc)
                begin
                    step_next = 2'd0;
                    busy_next = 1'b1;
                end
                else if (busy_reg && (step_reg == 2'd0))
                begin
                    quo_next  = AF_W'(prod >> SHIFT);
                    step_next = 2'd1;
                end
                else if (busy_reg && (step_reg == 2'd1))
                begin
                    rem_next  = OFF_W'(addr_reg - back_mul);
                    step_next = 2'd2;
                end
                else if (q_push)
                begin
                    busy_next = 1'b0;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    step_reg <= '0;
                end
                else
                begin
                    busy_reg <= busy_next;
                    step_reg <= step_next;
                end
            end

            always_ff @(posedge clk)
            begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                if (acc)
                begin
                    hold_reg <= dec;
                    addr_reg <= addr_m;
                end
            end
        end
    endgenerate

endmodule

`default_nettype wire

// ----- rtl/core/tlwpc_queue.sv -----
`default_nettype none

module tlwpc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tlwpc_pkg::job_t item_in,
    output logic                 full,
    input  wire logic            pop,
    output tlwpc_pkg::job_t      item_out,
    output logic                 empty
);

    tlwpc_pkg::job_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg;

    always_comb
    begin
        full     = (cnt_reg == 2'd2);
        empty    = (cnt_reg == 2'd0);
        item_out = mem_reg[rd_ptr_reg];
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tlwpc_back.sv -----
`default_nettype none

module tlwpc_back #(
    parameter int PAGE_BYTES = tlwpc_pkg::PageBytesDef,
    parameter int LOW_BYTES  = tlwpc_pkg::LowBytesDef
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    input  wire tlwpc_pkg::job_t  q_head,
    output logic                  q_pop,
    output tlwpc_pkg::result_t    result,
    output logic                  empty,
    input  wire logic             pop,
    output tlwpc_pkg::back_status_t status
);

    localparam int OFF_W      = $clog2(PAGE_BYTES);
    localparam int LINE_DEPTH = 2 * PAGE_BYTES;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int LOW_DEPTH  = (LOW_BYTES > 0) ? LOW_BYTES : 1;
    localparam int LOW_AW     = (LOW_DEPTH > 1) ? $clog2(LOW_DEPTH) : 1;
    localparam int CLR_DEPTH  = (LOW_DEPTH > LINE_DEPTH) ? LOW_DEPTH : LINE_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);
    localparam int PW         = tlwpc_pkg::PageW;

    function automatic logic [LINE_AW-1:0] line_addr(input logic sel,
                                                     input logic [OFF_W-1:0] off);
        logic [LINE_AW-1:0] base;
        base = sel ? LINE_AW'(PAGE_BYTES) : '0;
        return base + LINE_AW'(off);
    endfunction

    // Storage
    logic [7:0] line_mem [LINE_DEPTH];
    logic [7:0] low_mem  [LOW_DEPTH];
    logic [7:0] line_rd_reg;
    logic [7:0] low_rd_reg;

    logic               line_we, line_re, low_we, low_re;
    logic [LINE_AW-1:0] line_wa, line_ra;
    logic [LOW_AW-1:0]  low_wa, low_ra;
    logic [7:0]         line_wd, low_wd;

    // Control and line bookkeeping
    tlwpc_pkg::back_state_t state_reg, state_next;
    logic [CLR_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [1:0][PW-1:0]     tag_reg, tag_next;
    logic [1:0]             valid_reg, valid_next;
    logic [1:0]             dirty_reg, dirty_next;
    logic                   victim_reg, victim_next;
    logic                   pend_reg, pend_next;
    logic                   pend_wr_reg, pend_wr_next;
    logic [OFF_W-1:0]       pend_off_reg, pend_off_next;
    logic [7:0]             pend_byte_reg, pend_byte_next;
    logic [OFF_W-1:0]       fill_cnt_reg, fill_cnt_next;
    tlwpc_pkg::job_t        cur_reg, cur_next;
    logic [7:0]             old_reg, old_next;
    tlwpc_pkg::result_t     out_reg;
    logic                   out_valid_reg;

    tlwpc_pkg::result_t res;
    logic               out_load;
    logic               out_free;
    logic               err;
    logic               finish;
    logic               hit0, hit1, hit, hl;
    logic [OFF_W-1:0]   cur_off;
    logic               fill_last;

    always_comb
    begin
        out_free  = !out_valid_reg || pop;
        cur_off   = cur_reg.offset[OFF_W-1:0];
        hit0      = valid_reg[0] && (tag_reg[0] == cur_reg.page);
        hit1      = valid_reg[1] && (tag_reg[1] == cur_reg.page);
        hit       = hit0 || hit1;
        hl        = hit1 && !hit0;
        fill_last = (fill_cnt_reg == OFF_W'(PAGE_BYTES - 1));

        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        tag_next       = tag_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        victim_next    = victim_reg;
        pend_next      = pend_reg;
        pend_wr_next   = pend_wr_reg;
        pend_off_next  = pend_off_reg;
        pend_byte_next = pend_byte_reg;
        fill_cnt_next  = fill_cnt_reg;
        cur_next       = cur_reg;
        old_next       = old_reg;
        res            = '0;
        out_load       = 1'b0;
        err            = 1'b0;
        finish         = 1'b0;
        q_pop          = 1'b0;
        line_we = 1'b0;  line_wa = '0;  line_wd = '0;
        line_re = 1'b0;  line_ra = '0;
        low_we  = 1'b0;  low_wa  = '0;  low_wd  = '0;
        low_re  = 1'b0;  low_ra  = '0;

        case (state_reg)
            // Zero both stores after reset
            tlwpc_pkg::BK_CLEAR:
            begin
                line_we      = 32'(clr_cnt_reg) < 32'(LINE_DEPTH);
                line_wa      = clr_cnt_reg[LINE_AW-1:0];
                low_we       = 32'(clr_cnt_reg) < 32'(LOW_DEPTH);
                low_wa       = clr_cnt_reg[LOW_AW-1:0];
                clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = tlwpc_pkg::BK_IDLE;
                end
            end

            tlwpc_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_head;
                    state_next = tlwpc_pkg::BK_EXEC;
                end
            end

            tlwpc_pkg::BK_EXEC:
            begin
                case (cur_reg.cls)
                    tlwpc_pkg::CLS_FILL:
                    begin
                        if (pend_reg)
                        begin
                            line_re    = 1'b1;
                            line_ra    = line_addr(victim_reg, fill_cnt_reg);
                            state_next = tlwpc_pkg::BK_FILL_OLD;
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                    end
                    tlwpc_pkg::CLS_LOW:
                    begin
                        if (pend_reg)
                        begin
                            err = 1'b1;
                        end
                        else if (!cur_reg.is_write)
                        begin
                            low_re     = 1'b1;
                            low_ra     = cur_reg.offset[LOW_AW-1:0];
                            state_next = tlwpc_pkg::BK_RDOUT;
                        end
                        else if (out_free)
                        begin
                            low_we     = 1'b1;
                            low_wa     = cur_reg.offset[LOW_AW-1:0];
                            low_wd     = cur_reg.data;
                            res.kind   = tlwpc_pkg::KIND_WRITE;
                            out_load   = 1'b1;
                            state_next = tlwpc_pkg::BK_IDLE;
                        end
                    end
                    tlwpc_pkg::CLS_PAGE:
                    begin
                        if (pend_reg)
                        begin
                            err = 1'b1;
                        end
                        else if (hit && !cur_reg.is_write)
                        begin
                            line_re    = 1'b1;
                            line_ra    = line_addr(hl, cur_off);
                            state_next = tlwpc_pkg::BK_RDOUT;
                        end
                        else if (hit && out_free)
                        begin
                            line_we        = 1'b1;
                            line_wa        = line_addr(hl, cur_off);
                            line_wd        = cur_reg.data;
                            dirty_next[hl] = 1'b1;
                            res.kind       = tlwpc_pkg::KIND_WRITE;
                            out_load       = 1'b1;
                            state_next     = tlwpc_pkg::BK_IDLE;
                        end
                        else if (!hit && out_free)
                        begin
                            // Miss: victim takes the new tag, stays invalid until filled
                            res.kind             = tlwpc_pkg::KIND_MISS;
                            res.fill_page        = cur_reg.page;
                            res.writeback_needed = valid_reg[victim_reg] &&
                                                   dirty_reg[victim_reg];
                            res.writeback_page   = tag_reg[victim_reg];
                            tag_next[victim_reg]   = cur_reg.page;
                            valid_next[victim_reg] = 1'b0;
                            dirty_next[victim_reg] = 1'b0;
                            pend_next      = 1'b1;
                            pend_wr_next   = cur_reg.is_write;
                            pend_off_next  = cur_off;
                            pend_byte_next = cur_reg.data;
                            fill_cnt_next  = '0;
                            out_load       = 1'b1;
                            state_next     = tlwpc_pkg::BK_IDLE;
                        end
                    end
                    default:
                    begin
                        err = 1'b1;
                    end
                endcase
            end

            tlwpc_pkg::BK_RDOUT:
            begin
                if (out_free)
                begin
                    res.kind      = tlwpc_pkg::KIND_READ;
                    res.read_data = (cur_reg.cls == tlwpc_pkg::CLS_LOW) ? low_rd_reg
                                                                        : line_rd_reg;
                    out_load      = 1'b1;
                    state_next    = tlwpc_pkg::BK_IDLE;
                end
            end

            // Old victim byte is in the read register; replace it with the fill byte
            tlwpc_pkg::BK_FILL_OLD:
            begin
                if (fill_last)
                begin
                    line_we    = 1'b1;
                    line_wa    = line_addr(victim_reg, fill_cnt_reg);
                    line_wd    = cur_reg.data;
                    old_next   = line_rd_reg;
                    state_next = pend_wr_reg ? tlwpc_pkg::BK_FILL_WR
                                             : tlwpc_pkg::BK_FILL_RDI;
                end
                else if (out_free)
                begin
                    line_we         = 1'b1;
                    line_wa         = line_addr(victim_reg, fill_cnt_reg);
                    line_wd         = cur_reg.data;
                    res.kind        = tlwpc_pkg::KIND_FILL;
                    res.old_byte    = line_rd_reg;
                    res.fill_offset = tlwpc_pkg::FillOffW'(fill_cnt_reg);
                    fill_cnt_next   = fill_cnt_reg + OFF_W'(1);
                    out_load        = 1'b1;
                    state_next      = tlwpc_pkg::BK_IDLE;
                end
            end

            tlwpc_pkg::BK_FILL_WR:
            begin
                if (out_free)
                begin
                    line_we                = 1'b1;
                    line_wa                = line_addr(victim_reg, pend_off_reg);
                    line_wd                = pend_byte_reg;
                    dirty_next[victim_reg] = 1'b1;
                    finish                 = 1'b1;
                end
            end

            tlwpc_pkg::BK_FILL_RDI:
            begin
                line_re    = 1'b1;
                line_ra    = line_addr(victim_reg, pend_off_reg);
                state_next = tlwpc_pkg::BK_FILL_RDO;
            end

            tlwpc_pkg::BK_FILL_RDO:
            begin
                if (out_free)
                begin
                    res.read_data          = line_rd_reg;
                    dirty_next[victim_reg] = 1'b0;
                    finish                 = 1'b1;
                end
            end

            default:
            begin
                state_next = tlwpc_pkg::BK_IDLE;
            end
        endcase

        // Protocol error: no state change
        if (err && out_free)
        begin
            res.kind   = tlwpc_pkg::KIND_ERR;
            out_load   = 1'b1;
            state_next = tlwpc_pkg::BK_IDLE;
        end

        // Last fill step: line becomes valid, victim pointer moves on
        if (finish)
        begin
            res.kind               = tlwpc_pkg::KIND_FILL;
            res.old_byte           = old_reg;
            res.fill_offset        = tlwpc_pkg::FillOffW'(fill_cnt_reg);
            res.last               = 1'b1;
            valid_next[victim_reg] = 1'b1;
            victim_next            = !victim_reg;
            pend_next              = 1'b0;
            fill_cnt_next          = '0;
            out_load               = 1'b1;
            state_next             = tlwpc_pkg::BK_IDLE;
        end
    end

    always_comb
    begin
        result              = out_reg;
        empty               = !out_valid_reg;
        status.ready        = (state_reg != tlwpc_pkg::BK_CLEAR);
        status.fill_pending = pend_reg;
        status.victim_valid = valid_reg[victim_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlwpc_pkg::BK_CLEAR;
            clr_cnt_reg   <= '0;
            tag_reg       <= '0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            victim_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            pend_wr_reg   <= 1'b0;
            pend_off_reg  <= '0;
            pend_byte_reg <= '0;
            fill_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            tag_reg       <= tag_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            victim_reg    <= victim_next;
            pend_reg      <= pend_next;
            pend_wr_reg   <= pend_wr_next;
            pend_off_reg  <= pend_off_next;
            pend_byte_reg <= pend_byte_next;
            fill_cnt_reg  <= fill_cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        old_reg <= old_next;
        if (out_load)
        begin
            out_reg <= res;
        end
    end

    // Line store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_wa] <= line_wd;
        end
        if (line_re)
        begin
            line_rd_reg <= line_mem[line_ra];
        end
    end

    // Low RAM: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (low_we)
        begin
            low_mem[low_wa] <= low_wd;
        end
        if (low_re)
        begin
            low_rd_reg <= low_mem[low_ra];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/two_line_writeback_page_cache_unit.sv -----
// Byte-access cache in front of page-sized flash. Addresses below LOW_BYTES hit a local
// RAM; all others are checked against two fully associative page lines with round-robin
// replacement. A miss returns a page request; the flash then pushes the page one byte per
// item (mode fill), each answered with the victim's old byte for write-back, and the last
// one completes the pending access. After reset the block zeroes both stores with full held
// high. The front end decodes an item and parks it in a two-entry queue; the back end then
// takes the item from the queue and executes it, a read or a fill step going through a
// registered store read, and the last fill step adding the fill write that lands before
// the pending byte is written or read back. With a non power-of-two PAGE_BYTES the front
// end splits the address by a multiply with the rounded-up reciprocal of the page size
// and a multiply-subtract for the offset, taking no new item until the last one has
// gone into the queue.
`default_nettype none

module two_line_writeback_page_cache_unit #(
    parameter int PAGE_BYTES = tlwpc_pkg::PageBytesDef,
    parameter int LOW_BYTES  = tlwpc_pkg::LowBytesDef,
    parameter int ADDR_BITS  = tlwpc_pkg::AddrBitsDef
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire tlwpc_pkg::access_t access,
    output logic                    empty,
    input  wire logic               pop,
    output tlwpc_pkg::result_t      result
);

    logic                    q_push;
    logic                    q_full;
    logic                    q_pop;
    logic                    q_empty;
    tlwpc_pkg::job_t         q_in;
    tlwpc_pkg::job_t         q_head;
    tlwpc_pkg::back_status_t bk_status;

    tlwpc_front #(
        .PAGE_BYTES (PAGE_BYTES),
        .LOW_BYTES  (LOW_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .access (access),
        .ready  (bk_status.ready),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_in)
    );

    tlwpc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .item_out (q_head),
        .empty    (q_empty)
    );

    tlwpc_back #(
        .PAGE_BYTES (PAGE_BYTES),
        .LOW_BYTES  (LOW_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop),
        .status  (bk_status)
    );

    // Front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("item pushed into full queue");

    // The line being filled stays invalid until its last fill byte
    a_victim_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.fill_pending |-> !bk_status.victim_valid)
        else $error("victim line valid while fill pending");

    // No item is taken while the stores are being cleared
    a_hold_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !bk_status.ready |-> full)
        else $error("item accepted during clearing pass");

    // Back end takes nothing from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("pop from empty queue");

endmodule

`default_nettype wire
